/* src/msfm_pkg.sv */
// Shared types and constants for the motor sense and fault monitor.
package msfm_pkg;

  localparam int RAW_W      = 12;
  localparam int CUR_W      = 13;
  localparam int VOLT_W     = 16;
  localparam int TEMP_W     = 10;
  localparam int TIDX_W     = 7;
  localparam int TVAL_W     = 20;
  localparam int FAULT_W    = 2;
  localparam int RUN_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LIMIT_W    = 16;
  localparam int CNT_LIM_W  = 8;

  // Shared serial divider: numerator is left aligned, one quotient bit per cycle.
  localparam int DIV_NUM_W = 38;
  localparam int DIV_DEN_W = 25;
  localparam int DIV_CNT_W = 6;

  localparam int ITER_VOLT = 23;
  localparam int ITER_RES  = 38;
  localparam int ITER_FRAC = 20;

  // constant divides: floor(x * ceil(2^sh / d) / 2^sh) is exact over the operand range
  localparam int CUR_RECIP     = 1342178;  // divide by 100, 20-bit operand
  localparam int CUR_RECIP_SH  = 27;
  localparam int STEP_RECIP    = 838861;   // divide by 10, 20-bit operand
  localparam int STEP_RECIP_SH = 23;

  localparam int CUR_GAIN     = 161;
  localparam int VOLT_GAIN_SH = 5;      // 33 = 32 + 1
  localparam int VOLT_ADC_SH  = 12;     // divide by 4096
  localparam int NTC_NUM_K    = 33000000;
  localparam int NTC_DEN_BASE = 20480000;
  localparam int NTC_DEN_K    = 3300;
  localparam int DEG_SCALE    = 10;
  localparam int TEMP_MAX     = 1023;
  localparam int VOLT_MAX     = 65535;

  localparam int RESET_OFFSET   = 0;
  localparam int RESET_CUR_LIM  = 10000;
  localparam int RESET_VOLT_LIM = 600;
  localparam int RESET_CNT_LIM  = 10;
  localparam int RESET_DIV_TOP  = 100;
  localparam int RESET_DIV_BOT  = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUR_OFFSET = 3'd0,
    CFG_CUR_LIMIT  = 3'd1,
    CFG_VOLT_LIMIT = 3'd2,
    CFG_CNT_LIMIT  = 3'd3,
    CFG_DIV_TOP    = 3'd4,
    CFG_DIV_BOT    = 3'd5
  } cfg_reg_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE = 2'd0,
    FAULT_OC   = 2'd1,
    FAULT_OV   = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    DIV_VOLT,
    DIV_RES,
    DIV_FRAC
  } div_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CUR,
    S_VOLT,
    S_VOLT_W,
    S_RES,
    S_RES_W,
    S_SRCH,
    S_SRCH_W,
    S_RD_LO,
    S_RD_HI,
    S_CAP_HI,
    S_STEP,
    S_FRAC,
    S_FRAC_W,
    S_FIN
  } state_t;

  typedef struct packed {
    logic     in_load;
    logic     tbl_wr;
    logic     cap_cur;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_div;
    logic     volt_sat;
    logic     rd_lo;
    logic     rd_hi;
    logic     srch_upd;
    logic     cap_lo;
    logic     cap_hi;
    logic     cap_step;
    logic     frac_zero;
    logic     fin;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic srch_done;
    logic bottom_zero;
    logic frac_ok;
    logic step_zero;
    logic out_free;
  } status_t;

endpackage

/* src/msfm_if.sv */
// Valid/ready channel interfaces for samples, results and register writes.
interface msfm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [msfm_pkg::RAW_W-1:0]  current_raw;
  logic [msfm_pkg::RAW_W-1:0]  voltage_raw;
  logic [msfm_pkg::RAW_W-1:0]  temp_raw;
  logic [msfm_pkg::TIDX_W-1:0] table_index;
  logic [msfm_pkg::TVAL_W-1:0] table_value;
  modport source (output valid, cmd, current_raw, voltage_raw, temp_raw, table_index,
                  table_value, input ready);
  modport sink (input valid, cmd, current_raw, voltage_raw, temp_raw, table_index,
                table_value, output ready);
endinterface

interface msfm_out_if;
  logic                         valid;
  logic                         ready;
  logic [msfm_pkg::CUR_W-1:0]   current_ma;
  logic [msfm_pkg::VOLT_W-1:0]  bus_voltage_x10;
  logic [msfm_pkg::TEMP_W-1:0]  temperature_x10;
  logic [msfm_pkg::FAULT_W-1:0] fault_code;
  modport source (output valid, current_ma, bus_voltage_x10, temperature_x10, fault_code,
                  input ready);
  modport sink (input valid, current_ma, bus_voltage_x10, temperature_x10, fault_code,
                output ready);
endinterface

interface msfm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [msfm_pkg::CFG_IDX_W-1:0]  index;
  logic [msfm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/msfm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module msfm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 98,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/msfm_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module msfm_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [msfm_pkg::DIV_NUM_W-1:0] num,
  input  logic [msfm_pkg::DIV_DEN_W-1:0] den,
  input  logic [msfm_pkg::DIV_CNT_W-1:0] iters,
  output logic                           busy,
  output logic [msfm_pkg::DIV_NUM_W-1:0] quo
);

  localparam int NW = msfm_pkg::DIV_NUM_W;
  localparam int DW = msfm_pkg::DIV_DEN_W;
  localparam int CW = msfm_pkg::DIV_CNT_W;

  logic [NW-1:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   shifted, diff;
  logic          ge;

  always_comb begin
    shifted  = {rem_r, num_r[NW-1]};
    diff     = shifted - {1'b0, den_r};
    ge       = shifted >= {1'b0, den_r};
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_nxt  = {quo_r[NW-2:0], ge};
      num_nxt  = {num_r[NW-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

/* src/msfm_dp.sv */
// Datapath: registers, conversions, table search, fault counters and result register.
module msfm_dp #(
  parameter int TABLE_LAST_INDEX = 97
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [msfm_pkg::RAW_W-1:0]    in_current_raw,
  input  logic [msfm_pkg::RAW_W-1:0]    in_voltage_raw,
  input  logic [msfm_pkg::RAW_W-1:0]    in_temp_raw,
  input  logic [msfm_pkg::TIDX_W-1:0]   in_table_index,
  input  logic [msfm_pkg::TVAL_W-1:0]   in_table_value,
  msfm_cfg_if.sink                      cfg_ch,
  msfm_out_if.source                    out_ch,
  input  msfm_pkg::cmd_t                cmd,
  output msfm_pkg::status_t             status
);

  localparam int IDX_W  = $clog2(TABLE_LAST_INDEX + 1);
  localparam int CMP_W  = msfm_pkg::TIDX_W + 1;
  localparam int T_W    = IDX_W + 4;
  localparam int TSUM_W = msfm_pkg::TVAL_W + 1;
  localparam int RW     = msfm_pkg::RAW_W;
  localparam int VW     = msfm_pkg::TVAL_W;
  localparam int NW     = msfm_pkg::DIV_NUM_W;
  localparam int DW     = msfm_pkg::DIV_DEN_W;

  // configuration registers
  logic [RW-1:0]                      offset_r;
  logic [msfm_pkg::LIMIT_W-1:0]       cur_lim_r, volt_lim_r, top_r, bot_r;
  logic [msfm_pkg::CNT_LIM_W-1:0]     cnt_lim_r;

  logic [RW-1:0]                      cur_raw_r, volt_raw_r, temp_raw_r;
  logic [msfm_pkg::CUR_W-1:0]         cur_r;
  logic [msfm_pkg::VOLT_W-1:0]        volt_r;
  logic [VW-1:0]                      res_r, tlo_r, thi_r, step_r, frac_r;
  logic [IDX_W-1:0]                   hi_r, lo_r, mid, raddr;
  logic [msfm_pkg::RUN_W-1:0]         oc_run_r, ov_run_r, oc_run_nxt, ov_run_nxt;
  msfm_pkg::fault_t                   fault_r, fault_mid, fault_nxt;

  logic                               out_valid_r;
  logic [msfm_pkg::CUR_W-1:0]         out_cur_r;
  logic [msfm_pkg::VOLT_W-1:0]        out_volt_r;
  logic [msfm_pkg::TEMP_W-1:0]        out_temp_r;
  msfm_pkg::fault_t                   out_fault_r;

  logic [VW-1:0]                      rdata;
  logic                               tbl_we;

  logic [NW-1:0]                      div_num, div_quo;
  logic [DW-1:0]                      div_den;
  logic [msfm_pkg::DIV_CNT_W-1:0]     div_iters;
  logic                               div_busy;

  logic [RW-1:0]                      cur_diff;
  logic [19:0]                        cur_prod;
  logic [40:0]                        cur_mul;
  logic [msfm_pkg::CUR_W-1:0]         cur_q;
  logic [VW-1:0]                      step_diff;
  logic [43:0]                        step_mul;
  logic [VW-1:0]                      step_q;
  logic [16:0]                        volt_sum;
  logic [17:0]                        volt_raw33;
  logic [34:0]                        volt_prod;
  logic [NW-1:0]                      res_num;
  logic [DW-1:0]                      res_sub, res_den;
  logic [IDX_W:0]                     mid_sum;
  logic [IDX_W-1:0]                   span;
  logic [T_W-1:0]                     t_base;
  logic [TSUM_W-1:0]                  t_sum;
  logic [msfm_pkg::TEMP_W-1:0]        temp;
  logic                               oc_over, ov_over;

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= RW'(msfm_pkg::RESET_OFFSET);
      cur_lim_r  <= msfm_pkg::LIMIT_W'(msfm_pkg::RESET_CUR_LIM);
      volt_lim_r <= msfm_pkg::LIMIT_W'(msfm_pkg::RESET_VOLT_LIM);
      cnt_lim_r  <= msfm_pkg::CNT_LIM_W'(msfm_pkg::RESET_CNT_LIM);
      top_r      <= msfm_pkg::LIMIT_W'(msfm_pkg::RESET_DIV_TOP);
      bot_r      <= msfm_pkg::LIMIT_W'(msfm_pkg::RESET_DIV_BOT);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        msfm_pkg::CFG_CUR_OFFSET: offset_r   <= cfg_ch.data[RW-1:0];
        msfm_pkg::CFG_CUR_LIMIT:  cur_lim_r  <= cfg_ch.data;
        msfm_pkg::CFG_VOLT_LIMIT: volt_lim_r <= cfg_ch.data;
        msfm_pkg::CFG_CNT_LIMIT:  cnt_lim_r  <= cfg_ch.data[msfm_pkg::CNT_LIM_W-1:0];
        msfm_pkg::CFG_DIV_TOP:    top_r      <= cfg_ch.data;
        msfm_pkg::CFG_DIV_BOT:    bot_r      <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // NTC table
  assign tbl_we = cmd.tbl_wr &&
                  (CMP_W'(in_table_index) <= CMP_W'(TABLE_LAST_INDEX));

  assign mid_sum = (IDX_W + 1)'(hi_r) + (IDX_W + 1)'(lo_r);
  assign mid     = mid_sum[IDX_W:1];
  assign span    = hi_r - lo_r;

  always_comb begin
    raddr = mid;
    if (cmd.rd_lo) begin
      raddr = lo_r;
    end else if (cmd.rd_hi) begin
      raddr = hi_r;
    end
  end

  msfm_ram #(
    .WIDTH (VW),
    .DEPTH (TABLE_LAST_INDEX + 1)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IDX_W'(in_table_index)),
    .wdata (in_table_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // current and step divide by constants through reciprocal multiplies
  assign cur_diff   = cur_raw_r - offset_r;
  assign cur_prod   = (cur_raw_r > offset_r) ?
                      20'(cur_diff) * 20'(msfm_pkg::CUR_GAIN) : '0;
  assign cur_mul    = 41'(cur_prod) * 41'(msfm_pkg::CUR_RECIP);
  assign cur_q      = cur_mul[msfm_pkg::CUR_RECIP_SH +: msfm_pkg::CUR_W];
  assign step_diff  = tlo_r - thi_r;
  assign step_mul   = 44'(step_diff) * 44'(msfm_pkg::STEP_RECIP);
  assign step_q     = step_mul[msfm_pkg::STEP_RECIP_SH +: VW];

  // divider operands, numerators left aligned by the iteration count
  assign volt_sum   = 17'(top_r) + 17'(bot_r);
  assign volt_raw33 = (18'(volt_raw_r) << msfm_pkg::VOLT_GAIN_SH) + 18'(volt_raw_r);
  assign volt_prod  = 35'(volt_raw33) * 35'(volt_sum);
  assign res_num    = NW'(temp_raw_r) * NW'(msfm_pkg::NTC_NUM_K);
  assign res_sub    = DW'(temp_raw_r) * DW'(msfm_pkg::NTC_DEN_K);
  assign res_den    = DW'(msfm_pkg::NTC_DEN_BASE) - res_sub;

  always_comb begin
    case (cmd.div_sel)
      msfm_pkg::DIV_VOLT: begin
        div_num   = {volt_prod[34:msfm_pkg::VOLT_ADC_SH], 15'b0};
        div_den   = DW'(bot_r);
        div_iters = msfm_pkg::DIV_CNT_W'(msfm_pkg::ITER_VOLT);
      end
      msfm_pkg::DIV_RES: begin
        div_num   = res_num;
        div_den   = res_den;
        div_iters = msfm_pkg::DIV_CNT_W'(msfm_pkg::ITER_RES);
      end
      msfm_pkg::DIV_FRAC: begin
        div_num   = {tlo_r - res_r, 18'b0};
        div_den   = DW'(step_r);
        div_iters = msfm_pkg::DIV_CNT_W'(msfm_pkg::ITER_FRAC);
      end
      default: begin
        div_num   = '0;
        div_den   = '0;
        div_iters = '0;
      end
    endcase
  end

  msfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      cur_raw_r  <= in_current_raw;
      volt_raw_r <= in_voltage_raw;
      temp_raw_r <= in_temp_raw;
      hi_r       <= IDX_W'(TABLE_LAST_INDEX);
      lo_r       <= '0;
    end
    if (cmd.cap_cur) begin
      cur_r <= cur_q;
    end
    if (cmd.cap_div) begin
      case (cmd.div_sel)
        msfm_pkg::DIV_VOLT: volt_r <= (div_quo > NW'(msfm_pkg::VOLT_MAX)) ?
                                      msfm_pkg::VOLT_W'(msfm_pkg::VOLT_MAX) :
                                      div_quo[msfm_pkg::VOLT_W-1:0];
        msfm_pkg::DIV_RES:  res_r  <= div_quo[VW-1:0];
        msfm_pkg::DIV_FRAC: frac_r <= div_quo[VW-1:0];
        default: ;
      endcase
    end
    if (cmd.volt_sat) begin
      volt_r <= msfm_pkg::VOLT_W'(msfm_pkg::VOLT_MAX);
    end
    if (cmd.srch_upd) begin
      if (rdata < res_r) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid;
      end
    end
    if (cmd.cap_lo) begin
      tlo_r <= rdata;
    end
    if (cmd.cap_hi) begin
      thi_r <= rdata;
    end
    if (cmd.cap_step) begin
      step_r <= step_q;
    end
    if (cmd.frac_zero) begin
      frac_r <= '0;
    end
  end

  // temperature assembly
  assign t_base = T_W'(lo_r) * T_W'(msfm_pkg::DEG_SCALE);
  assign t_sum  = TSUM_W'(t_base) + TSUM_W'(frac_r);
  assign temp   = (t_sum > TSUM_W'(msfm_pkg::TEMP_MAX)) ?
                  msfm_pkg::TEMP_W'(msfm_pkg::TEMP_MAX) : t_sum[msfm_pkg::TEMP_W-1:0];

  // fault runs: current first, voltage sees the fault current may have latched
  assign oc_over = 16'(cur_r) >= cur_lim_r;
  assign ov_over = volt_r >= volt_lim_r;

  always_comb begin
    fault_mid  = fault_r;
    oc_run_nxt = '0;
    if (oc_over && fault_r == msfm_pkg::FAULT_NONE) begin
      oc_run_nxt = (&oc_run_r) ? oc_run_r : oc_run_r + 1'b1;
      if (oc_run_nxt >= cnt_lim_r) begin
        fault_mid = msfm_pkg::FAULT_OC;
      end
    end
    fault_nxt  = fault_mid;
    ov_run_nxt = '0;
    if (ov_over && fault_mid == msfm_pkg::FAULT_NONE) begin
      ov_run_nxt = (&ov_run_r) ? ov_run_r : ov_run_r + 1'b1;
      if (ov_run_nxt >= cnt_lim_r) begin
        fault_nxt = msfm_pkg::FAULT_OV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r     <= msfm_pkg::FAULT_NONE;
      oc_run_r    <= '0;
      ov_run_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin) begin
        fault_r     <= fault_nxt;
        oc_run_r    <= oc_run_nxt;
        ov_run_r    <= ov_run_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_cur_r   <= cur_r;
      out_volt_r  <= volt_r;
      out_temp_r  <= temp;
      out_fault_r <= fault_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.current_ma      = out_cur_r;
  assign out_ch.bus_voltage_x10 = out_volt_r;
  assign out_ch.temperature_x10 = out_temp_r;
  assign out_ch.fault_code      = out_fault_r;

  assign status.div_busy    = div_busy;
  assign status.srch_done   = span <= IDX_W'(1);
  assign status.bottom_zero = bot_r == '0;
  assign status.frac_ok     = (tlo_r > thi_r) && (tlo_r >= res_r);
  assign status.step_zero   = step_r == '0;
  assign status.out_free    = !out_valid_r || out_ch.ready;

endmodule

/* src/msfm_ctrl.sv */
// Controller: sequences conversions, divisions, table search and result hand-off.
module msfm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_cmd,
  output logic                  in_ready,
  input  msfm_pkg::status_t     status,
  output msfm_pkg::cmd_t        cmd
);

  msfm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msfm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.div_sel = msfm_pkg::DIV_VOLT;
    case (state_r)
      msfm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          if (in_cmd) begin
            cmd.tbl_wr = 1'b1;
          end else begin
            state_nxt = msfm_pkg::S_CUR;
          end
        end
      end
      msfm_pkg::S_CUR: begin
        cmd.cap_cur = 1'b1;
        state_nxt   = msfm_pkg::S_VOLT;
      end
      msfm_pkg::S_VOLT: begin
        cmd.div_sel = msfm_pkg::DIV_VOLT;
        if (status.bottom_zero) begin
          cmd.volt_sat = 1'b1;
          state_nxt    = msfm_pkg::S_RES;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = msfm_pkg::S_VOLT_W;
        end
      end
      msfm_pkg::S_VOLT_W: begin
        cmd.div_sel = msfm_pkg::DIV_VOLT;
        if (!status.div_busy) begin
          cmd.cap_div = 1'b1;
          state_nxt   = msfm_pkg::S_RES;
        end
      end
      msfm_pkg::S_RES: begin
        cmd.div_sel   = msfm_pkg::DIV_RES;
        cmd.div_start = 1'b1;
        state_nxt     = msfm_pkg::S_RES_W;
      end
      msfm_pkg::S_RES_W: begin
        cmd.div_sel = msfm_pkg::DIV_RES;
        if (!status.div_busy) begin
          cmd.cap_div = 1'b1;
          state_nxt   = msfm_pkg::S_SRCH;
        end
      end
      msfm_pkg::S_SRCH: begin
        // the midpoint address goes out here, data returns next cycle
        state_nxt = status.srch_done ? msfm_pkg::S_RD_LO : msfm_pkg::S_SRCH_W;
      end
      msfm_pkg::S_SRCH_W: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = msfm_pkg::S_SRCH;
      end
      msfm_pkg::S_RD_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = msfm_pkg::S_RD_HI;
      end
      msfm_pkg::S_RD_HI: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_hi  = 1'b1;
        state_nxt  = msfm_pkg::S_CAP_HI;
      end
      msfm_pkg::S_CAP_HI: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = msfm_pkg::S_STEP;
      end
      msfm_pkg::S_STEP: begin
        if (status.frac_ok) begin
          cmd.cap_step = 1'b1;
          state_nxt    = msfm_pkg::S_FRAC;
        end else begin
          cmd.frac_zero = 1'b1;
          state_nxt     = msfm_pkg::S_FIN;
        end
      end
      msfm_pkg::S_FRAC: begin
        cmd.div_sel = msfm_pkg::DIV_FRAC;
        if (status.step_zero) begin
          cmd.frac_zero = 1'b1;
          state_nxt     = msfm_pkg::S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = msfm_pkg::S_FRAC_W;
        end
      end
      msfm_pkg::S_FRAC_W: begin
        cmd.div_sel = msfm_pkg::DIV_FRAC;
        if (!status.div_busy) begin
          cmd.cap_div = 1'b1;
          state_nxt   = msfm_pkg::S_FIN;
        end
      end
      msfm_pkg::S_FIN: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = msfm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = msfm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* src/motor_sense_fault_monitor.sv */
// Top level of the motor sense and fault monitor.
//
//   channel | dir | handshake       | payload
//   in_ch   | in  | valid / ready   | cmd, current/voltage/temp raw, table index/value
//   out_ch  | out | valid / ready   | current_ma, bus_voltage_x10, temperature_x10, fault
//   cfg_ch  | in  | valid / ready   | index, data (always ready)
//
// A table write transfer is handled in the idle state without leaving it. A sample set
// runs three passes of the shared one-bit-per-cycle divider (23, 38 and 20 bits) and,
// with the default table, six or seven binary search steps of an address state and an
// update state each; a zero lower divider or no fraction skips the matching pass.
// Reset is synchronous and active low; table contents stay undefined until written.
// A waiting result does not block the next transfer in; the controller holds only at
// the end of a sample until the result register is free.
module motor_sense_fault_monitor #(
  parameter int TABLE_LAST_INDEX = 97
) (
  input  logic        clk,
  input  logic        rst_n,
  msfm_in_if.sink     in_ch,
  msfm_out_if.source  out_ch,
  msfm_cfg_if.sink    cfg_ch
);

  msfm_pkg::cmd_t    cmd;
  msfm_pkg::status_t status;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  msfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  msfm_dp #(
    .TABLE_LAST_INDEX (TABLE_LAST_INDEX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_current_raw (in_ch.current_raw),
    .in_voltage_raw (in_ch.voltage_raw),
    .in_temp_raw    (in_ch.temp_raw),
    .in_table_index (in_ch.table_index),
    .in_table_value (in_ch.table_value),
    .cfg_ch         (cfg_ch),
    .out_ch         (out_ch),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

/* verif/msfm_checker.sv */
// Passive checker: predicts each sample result and compares it with the output transfer.
module msfm_checker #(
  parameter int TABLE_LAST_INDEX = 97
) (
  input  logic clk,
  input  logic rst_n,
  msfm_in_if   in_ch,
  msfm_out_if  out_ch,
  msfm_cfg_if  cfg_ch,
  output int   errors,
  output int   outstanding,
  output int   results_checked,
  output int   table_writes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [msfm_pkg::CUR_W-1:0]   current_ma;
    logic [msfm_pkg::VOLT_W-1:0]  bus_voltage_x10;
    logic [msfm_pkg::TEMP_W-1:0]  temperature_x10;
    logic [msfm_pkg::FAULT_W-1:0] fault_code;
  } reading_t;

  reading_t expected_readings[$];

  logic [msfm_pkg::RAW_W-1:0]     offset_q;
  logic [msfm_pkg::LIMIT_W-1:0]   cur_lim_q;
  logic [msfm_pkg::LIMIT_W-1:0]   volt_lim_q;
  logic [msfm_pkg::CNT_LIM_W-1:0] cnt_lim_q;
  logic [15:0]                    top_q;
  logic [15:0]                    bot_q;
  logic [msfm_pkg::TVAL_W-1:0]    ntc_q [0:TABLE_LAST_INDEX];
  logic [msfm_pkg::RUN_W-1:0]     oc_run_q;
  logic [msfm_pkg::RUN_W-1:0]     ov_run_q;
  msfm_pkg::fault_t               latched_q;

  function automatic void bump_run(inout logic [msfm_pkg::RUN_W-1:0] run, input logic over,
                                   input msfm_pkg::fault_t code);
    if (over && latched_q == msfm_pkg::FAULT_NONE) begin
      if (run < 8'd255) run++;
      if (run >= cnt_lim_q) latched_q = code;
    end else begin
      run = '0;
    end
  endfunction

  function automatic logic [msfm_pkg::VOLT_W-1:0] bus_volts(
      input logic [msfm_pkg::RAW_W-1:0] raw);
    longint unsigned num;
    longint unsigned den;
    longint unsigned v;
    if (bot_q == 0) return 16'hFFFF;
    num = longint'(raw) * 33 * (longint'(top_q) + longint'(bot_q));
    den = 4096 * longint'(bot_q);
    v = num / den;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [msfm_pkg::TEMP_W-1:0] ntc_temp(
      input logic [msfm_pkg::RAW_W-1:0] raw);
    longint unsigned num;
    longint unsigned den;
    int unsigned r;
    int unsigned hi;
    int unsigned lo;
    int unsigned mid;
    int unsigned step;
    int unsigned frac;
    int unsigned t;
    num = 64'd33000000 * raw;
    den = 64'd20480000 - 64'd3300 * raw;
    r = int'(num / den);
    hi = TABLE_LAST_INDEX;
    lo = 0;
    while (hi - lo > 1) begin
      mid = (hi + lo) / 2;
      if (ntc_q[mid] < r) hi = mid;
      else lo = mid;
    end
    frac = 0;
    // flat or rising neighbors and resistance above the low entry give no fraction
    if (ntc_q[lo] > ntc_q[hi] && ntc_q[lo] >= r) begin
      step = (ntc_q[lo] - ntc_q[hi]) / 10;
      if (step != 0) frac = (ntc_q[lo] - r) / step;
    end
    t = 10 * lo;
    if (t > 1023 || frac > 1023 - t) return 10'd1023;
    return msfm_pkg::TEMP_W'(t + frac);
  endfunction

  function automatic reading_t predict_reading(input logic [msfm_pkg::RAW_W-1:0] cur_raw,
                                               input logic [msfm_pkg::RAW_W-1:0] volt_raw,
                                               input logic [msfm_pkg::RAW_W-1:0] temp_raw);
    reading_t rd;
    int unsigned cur;
    cur = (cur_raw <= offset_q) ? 0 : ((cur_raw - offset_q) * 161) / 100;
    bump_run(oc_run_q, cur >= cur_lim_q, msfm_pkg::FAULT_OC);
    rd.current_ma = cur[msfm_pkg::CUR_W-1:0];
    rd.bus_voltage_x10 = bus_volts(volt_raw);
    bump_run(ov_run_q, rd.bus_voltage_x10 >= volt_lim_q, msfm_pkg::FAULT_OV);
    rd.temperature_x10 = ntc_temp(temp_raw);
    rd.fault_code = latched_q;
    return rd;
  endfunction

  reading_t got;
  reading_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      offset_q   <= msfm_pkg::RESET_OFFSET;
      cur_lim_q  <= msfm_pkg::RESET_CUR_LIM;
      volt_lim_q <= msfm_pkg::RESET_VOLT_LIM;
      cnt_lim_q  <= msfm_pkg::RESET_CNT_LIM;
      top_q      <= msfm_pkg::RESET_DIV_TOP;
      bot_q      <= msfm_pkg::RESET_DIV_BOT;
      oc_run_q   <= '0;
      ov_run_q   <= '0;
      latched_q  <= msfm_pkg::FAULT_NONE;
      expected_readings.delete();
      outstanding <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (msfm_pkg::cfg_reg_t'(cfg_ch.index))
          msfm_pkg::CFG_CUR_OFFSET: offset_q   = cfg_ch.data[msfm_pkg::RAW_W-1:0];
          msfm_pkg::CFG_CUR_LIMIT:  cur_lim_q  = cfg_ch.data;
          msfm_pkg::CFG_VOLT_LIMIT: volt_lim_q = cfg_ch.data;
          msfm_pkg::CFG_CNT_LIMIT:  cnt_lim_q  = cfg_ch.data[msfm_pkg::CNT_LIM_W-1:0];
          msfm_pkg::CFG_DIV_TOP:    top_q      = cfg_ch.data;
          msfm_pkg::CFG_DIV_BOT:    bot_q      = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.current_ma, out_ch.bus_voltage_x10, out_ch.temperature_x10,
                out_ch.fault_code};
        if (expected_readings.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_readings.pop_front();
          results_checked++;
          if (got.current_ma !== want.current_ma) begin
            $error("current_ma expected %0d got %0d", want.current_ma, got.current_ma);
            errors++;
          end
          if (got.bus_voltage_x10 !== want.bus_voltage_x10) begin
            $error("bus_voltage_x10 expected %0d got %0d", want.bus_voltage_x10,
                   got.bus_voltage_x10);
            errors++;
          end
          if (got.temperature_x10 !== want.temperature_x10) begin
            $error("temperature_x10 expected %0d got %0d", want.temperature_x10,
                   got.temperature_x10);
            errors++;
          end
          if (got.fault_code !== want.fault_code) begin
            $error("fault_code expected %0d got %0d", want.fault_code, got.fault_code);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd) begin
          table_writes++;
          if (in_ch.table_index <= TABLE_LAST_INDEX) begin
            ntc_q[in_ch.table_index] = in_ch.table_value;
          end
        end else begin
          expected_readings.push_back(predict_reading(in_ch.current_raw, in_ch.voltage_raw,
                                                      in_ch.temp_raw));
        end
      end
      outstanding <= expected_readings.size();
    end
  end

  initial begin
    errors = 0;
    results_checked = 0;
    table_writes = 0;
  end

endmodule

/* verif/motor_sense_fault_monitor_test.sv */
// Stimulus and verdict for the motor sense and fault monitor.
module motor_sense_fault_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAST_IDX   = 97;
  localparam int SETTLE     = 400;
  localparam int CYCLE_CAP  = 3000000;
  localparam int PHASE_ITEMS = 58;

  logic clk;
  logic rst_n;
  int   errors;
  int   outstanding;
  int   results_checked;
  int   table_writes;
  int   settings_used;
  int   burst_left;
  int   stall_left;
  int   mode_left;
  logic choppy;
  logic oc_latch;

  msfm_in_if  in_ch ();
  msfm_out_if out_ch ();
  msfm_cfg_if cfg_ch ();

  motor_sense_fault_monitor #(.TABLE_LAST_INDEX(LAST_IDX)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  msfm_checker #(.TABLE_LAST_INDEX(LAST_IDX)) checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .outstanding(outstanding), .results_checked(results_checked),
    .table_writes(table_writes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("FAIL motor_sense_fault_monitor");
    $finish;
  end

  // receiver: calm and choppy stretches follow each other in random order
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
    mode_left = 0;
    choppy = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(300, 20);
        choppy = $urandom_range(1);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (choppy && $urandom_range(31) == 0) begin
        stall_left = $urandom_range(24, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(choppy && $urandom_range(3) == 0);
      end
    end
  end

  task automatic send_in(input logic cmd, input logic [msfm_pkg::RAW_W-1:0] cur,
                         input logic [msfm_pkg::RAW_W-1:0] volt,
                         input logic [msfm_pkg::RAW_W-1:0] temp,
                         input logic [msfm_pkg::TIDX_W-1:0] idx,
                         input logic [msfm_pkg::TVAL_W-1:0] val);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(16, 1);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.current_raw <= cur;
    in_ch.voltage_raw <= volt;
    in_ch.temp_raw    <= temp;
    in_ch.table_index <= idx;
    in_ch.table_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic send_sample(input logic [msfm_pkg::RAW_W-1:0] cur,
                             input logic [msfm_pkg::RAW_W-1:0] volt,
                             input logic [msfm_pkg::RAW_W-1:0] temp);
    send_in(1'b0, cur, volt, temp, $urandom, $urandom);
  endtask

  task automatic send_entry(input logic [msfm_pkg::TIDX_W-1:0] idx,
                            input logic [msfm_pkg::TVAL_W-1:0] val);
    send_in(1'b1, $urandom, $urandom, $urandom, idx, val);
  endtask

  function automatic logic [msfm_pkg::RAW_W-1:0] pick_raw();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_sample();
    // an under-limit sample now and then keeps the run counters from latching
    if ($urandom_range(7) == 0) send_sample('0, '0, $urandom);
    else send_sample(pick_raw(), pick_raw(), pick_raw());
  endtask

  // hold the sender until every result is back, then let the pipeline drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [msfm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [msfm_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [msfm_pkg::CFG_DATA_W-1:0] off,
                           input logic [msfm_pkg::CFG_DATA_W-1:0] clim,
                           input logic [msfm_pkg::CFG_DATA_W-1:0] vlim,
                           input logic [msfm_pkg::CFG_DATA_W-1:0] cnt,
                           input logic [msfm_pkg::CFG_DATA_W-1:0] top,
                           input logic [msfm_pkg::CFG_DATA_W-1:0] bot);
    write_reg(msfm_pkg::CFG_CUR_OFFSET, off);
    write_reg(msfm_pkg::CFG_CUR_LIMIT, clim);
    write_reg(msfm_pkg::CFG_VOLT_LIMIT, vlim);
    write_reg(msfm_pkg::CFG_CNT_LIMIT, cnt);
    write_reg(msfm_pkg::CFG_DIV_TOP, top);
    write_reg(msfm_pkg::CFG_DIV_BOT, bot);
    settings_used++;
  endtask

  // 0 descending NTC curve, 1 jittery neighbors (flat and rising steps), 2 noise
  task automatic load_table(input int shape);
    int unsigned t;
    int unsigned v;
    t = $urandom_range(1048575, 600000);
    for (int i = 0; i <= LAST_IDX; i++) begin
      case (shape)
        0: begin
          v = t;
          t = (t * $urandom_range(97, 88)) / 100;
        end
        1: begin
          v = t;
          t = t + 4 - $urandom_range(15);
        end
        default: v = (i == 0) ? 20'hFFFFF : (i == LAST_IDX) ? 0 : $urandom_range(20'hFFFFF);
      endcase
      send_entry(i, v);
    end
  endtask

  task automatic random_phase(input int items);
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(11) == 0) send_entry($urandom_range(127), $urandom);
      else random_sample();
    end
  endtask

  // limits that sit inside the reachable range so over and under both occur
  task automatic counting_setup(input logic [msfm_pkg::CFG_DATA_W-1:0] off,
                                input logic [msfm_pkg::CFG_DATA_W-1:0] top,
                                input logic [msfm_pkg::CFG_DATA_W-1:0] bot,
                                input logic [msfm_pkg::CFG_DATA_W-1:0] cnt);
    longint unsigned vmax;
    int unsigned clim;
    int unsigned vlim;
    vmax = (64'd4095 * 33 * (top + bot)) / (64'd4096 * bot);
    if (vmax > 65534) vmax = 65534;
    clim = ($urandom_range(4095) * 161) / 100 + 1;
    vlim = $urandom_range(vmax) + 1;
    write_all(off, clim, vlim, cnt, top, bot);
  endtask

  initial begin
    rst_n = 1'b0;
    settings_used = 0;
    burst_left = 0;
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.current_raw = '0;
    in_ch.voltage_raw = '0;
    in_ch.temp_raw = '0;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_table(0);
    // directed: field extremes at reset settings, then ignored table indexes
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(12'd1, 12'd2048, 12'd2048);
    send_sample(12'd4094, 12'd1, 12'd4094);
    send_sample(12'd2048, 12'd100, 12'd1);
    send_entry(7'd98, '1);
    send_entry(7'd127, '1);
    send_sample(12'd3000, 12'd3000, 12'd3000);
    settle();

    write_reg(3'd6, $urandom);
    write_reg(3'd7, $urandom);
    write_all(msfm_pkg::RESET_OFFSET, msfm_pkg::RESET_CUR_LIM, msfm_pkg::RESET_VOLT_LIM, 255,
              msfm_pkg::RESET_DIV_TOP, msfm_pkg::RESET_DIV_BOT);
    send_sample(12'd100, '0, '0);
    send_sample(12'd50, '1, '1);
    send_sample('1, 12'd80, 12'd512);
    settle();

    // counting phases: runs build and clear, nothing latches
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: counting_setup(0, msfm_pkg::RESET_DIV_TOP, msfm_pkg::RESET_DIV_BOT, 255);
        1: counting_setup(12'hFFF, 16'hFFFF, 16'hFFFF, 255);
        2: counting_setup(0, 0, 1, 255);
        3: counting_setup($urandom, 0, 16'hFFFF, $urandom_range(255, 200));
        4: counting_setup($urandom_range(200), 16'hFFFF, 1, $urandom_range(255, 200));
        default: counting_setup($urandom_range(600), $urandom_range(65535),
                                $urandom_range(65535, 1), $urandom_range(255, 200));
      endcase
      if (p == 1) load_table(1);
      if (p == 3) load_table(2);
      if (p == 4) load_table(0);
      random_phase(PHASE_ITEMS);
      settle();
    end

    // latch one fault for the rest of the run
    oc_latch = $urandom_range(1);
    write_all($urandom_range(100), oc_latch ? 16'd0 : 16'hFFFF, oc_latch ? 16'hFFFF : 16'd0,
              $urandom_range(1) ? 16'd1 : $urandom_range(8, 2), msfm_pkg::RESET_DIV_TOP,
              msfm_pkg::RESET_DIV_BOT);
    for (int n = 0; n < 30; n++) send_sample(pick_raw(), pick_raw(), pick_raw());
    settle();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: write_all(12'hFFF, 0, 0, 0, 16'hFFFF, 0);
        1: write_all(0, 16'hFFFF, 16'hFFFF, 1, 0, 16'hFFFF);
        default: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      if (p == 1) load_table(0);
      random_phase(PHASE_ITEMS);
      settle();
    end

    $display("covered %0d sample results, %0d table writes, %0d register settings",
             results_checked, table_writes, settings_used);
    $display("fault latched by %s", oc_latch ? "overcurrent" : "overvoltage");
    if (errors == 0) begin
      $display("PASS motor_sense_fault_monitor");
    end else begin
      $display("FAIL motor_sense_fault_monitor");
    end
    $finish;
  end

endmodule

/* sim.f */
src/msfm_pkg.sv
src/msfm_if.sv
src/msfm_ram.sv
src/msfm_div.sv
src/msfm_dp.sv
src/msfm_ctrl.sv
src/motor_sense_fault_monitor.sv
verif/msfm_checker.sv
verif/motor_sense_fault_monitor_test.sv
